// File: rtl/core/cfr_pkg.sv
// Shared types and codes for the clock frame replacement block.
`default_nettype none

package cfr_pkg;

  // Request codes on the action field.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes.
  localparam logic ST_DONE      = 1'b0;
  localparam logic ST_NOT_FOUND = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SWEEP_RD,
    S_SWEEP,
    S_WALK,
    S_UNLINK_RD,
    S_UNLINK,
    S_INSERT,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // capture input beat, restart scan
    logic scan_step;   // move scan index on
    logic scan_take;   // claim scanned free slot
    logic sweep_rd;    // fetch successor of the hand
    logic sweep_step;  // move hand one slot, clear or pick
    logic take_free;   // target slot is the freed index
    logic walk_start;  // start predecessor search at head
    logic walk_step;   // follow one link of the search
    logic unlink_rd;   // fetch successor and payload of target
    logic unlink;      // take target out of the order list
    logic insert;      // fill target and append at tail
    logic result;      // load the output register
    logic result_err;  // result carries not_found
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_alloc;
    logic free_valid;
    logic free_is_head;
    logic scan_free;
    logic scan_last;
    logic sweep_hit;
    logic walk_match;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/core/cfr_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/cfr_ctrl.sv
// Controller state machine for the clock frame replacement block.
`default_nettype none

module cfr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cfr_pkg::stat_t st,
  output cfr_pkg::cmd_t      cmd
);
  import cfr_pkg::*;

  state_t state_r, state_nxt;
  logic   err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.accept) begin
        err_r <= 1'b0;
      end else if (state_r == S_START && !st.is_alloc && !st.free_valid) begin
        err_r <= 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_START;
      end
      S_START: begin
        priority if (st.is_alloc)    state_nxt = S_SCAN;
        else if (!st.free_valid)     state_nxt = S_DONE;
        else if (st.free_is_head)    state_nxt = S_UNLINK_RD;
        else                         state_nxt = S_WALK;
      end
      S_SCAN: begin
        priority if (st.scan_free)   state_nxt = S_INSERT;
        else if (st.scan_last)       state_nxt = S_SWEEP_RD;
        else                         state_nxt = S_SCAN;
      end
      S_SWEEP_RD: state_nxt = S_SWEEP;
      S_SWEEP: begin
        if (st.sweep_hit) state_nxt = S_UNLINK_RD;
      end
      S_WALK: begin
        if (st.walk_match) state_nxt = S_UNLINK_RD;
      end
      S_UNLINK_RD: state_nxt = S_UNLINK;
      S_UNLINK: state_nxt = st.is_alloc ? S_INSERT : S_DONE;
      S_INSERT: state_nxt = S_DONE;
      S_DONE: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_START: begin
        if (!st.is_alloc && st.free_valid) begin
          cmd.take_free  = 1'b1;
          cmd.walk_start = !st.free_is_head;
        end
      end
      S_SCAN: begin
        cmd.scan_take = st.scan_free;
        cmd.scan_step = !st.scan_free && !st.scan_last;
      end
      S_SWEEP_RD:  cmd.sweep_rd   = 1'b1;
      S_SWEEP:     cmd.sweep_step = 1'b1;
      S_WALK:      cmd.walk_step  = !st.walk_match;
      S_UNLINK_RD: cmd.unlink_rd  = 1'b1;
      S_UNLINK:    cmd.unlink     = 1'b1;
      S_INSERT:    cmd.insert     = 1'b1;
      S_DONE: begin
        cmd.result     = st.out_free;
        cmd.result_err = err_r;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/cfr_datapath.sv
// Datapath: slot table, order list, clock hand and result register.
`default_nettype none

module cfr_datapath #(
  parameter int FRAME_SLOTS      = 64,
  parameter int PAGE_NUMBER_BITS = 20,
  parameter int OWNER_BITS       = 8,
  localparam int SLOT_W          = $clog2(FRAME_SLOTS),
  localparam int CNT_W           = $clog2(FRAME_SLOTS + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [CNT_W-1:0]            cfg_wdata,
  input  wire logic                        in_action,
  input  wire logic [PAGE_NUMBER_BITS-1:0] in_page_number,
  input  wire logic [OWNER_BITS-1:0]       in_owner_id,
  input  wire logic                        in_zero_fill,
  input  wire logic [SLOT_W-1:0]           in_frame_index,
  input  wire cfr_pkg::cmd_t               cmd,
  output cfr_pkg::stat_t                   st,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_status,
  output logic [SLOT_W-1:0]                out_granted_slot,
  output logic                             out_clear_frame,
  output logic                             out_evicted,
  output logic [PAGE_NUMBER_BITS-1:0]      out_victim_page,
  output logic [OWNER_BITS-1:0]            out_victim_owner
);
  import cfr_pkg::*;

  localparam int PO_W = PAGE_NUMBER_BITS + OWNER_BITS;

  // Captured request.
  logic                        act_r;
  logic [PAGE_NUMBER_BITS-1:0] page_r;
  logic [OWNER_BITS-1:0]       owner_r;
  logic                        zero_r;
  logic [SLOT_W-1:0]           findex_r;

  // Table and list state.
  logic [CNT_W-1:0]       limit_r;
  logic [FRAME_SLOTS-1:0] valid_r;
  logic [FRAME_SLOTS-1:0] ref_r;
  logic [SLOT_W-1:0]      head_r, tail_r, hand_r;
  logic                   unset_r;
  logic [CNT_W-1:0]       count_r;

  // Working registers.
  logic [SLOT_W-1:0]           idx_r, slot_r, pred_r;
  logic                        evict_r;
  logic [PAGE_NUMBER_BITS-1:0] vpage_r;
  logic [OWNER_BITS-1:0]       vowner_r;

  // Memories.
  logic              nx_we;
  logic [SLOT_W-1:0] nx_waddr, nx_wdata, nx_raddr, nx_rdata;
  logic [PO_W-1:0]   po_rdata;

  logic [SLOT_W-1:0] hand_nxt;
  logic [SLOT_W-1:0] lim_last;

  cfr_ram #(.WIDTH(SLOT_W), .DEPTH(FRAME_SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (nx_raddr),
    .rdata (nx_rdata)
  );

  cfr_ram #(.WIDTH(PO_W), .DEPTH(FRAME_SLOTS)) u_page_ram (
    .clk   (clk),
    .we    (cmd.insert),
    .waddr (slot_r),
    .wdata ({page_r, owner_r}),
    .raddr (slot_r),
    .rdata (po_rdata)
  );

  // Hand advance: wrap to head from tail or when unset.
  assign hand_nxt = (unset_r || hand_r == tail_r) ? head_r : nx_rdata;

  // Clamp the limit to 1..FRAME_SLOTS and take the last scanned index.
  always_comb begin
    priority if (limit_r == '0) begin
      lim_last = '0;
    end else if (limit_r > CNT_W'(FRAME_SLOTS)) begin
      lim_last = SLOT_W'(FRAME_SLOTS - 1);
    end else begin
      lim_last = SLOT_W'(limit_r - 1'b1);
    end
  end

  always_comb begin
    priority if (cmd.sweep_rd)   nx_raddr = hand_r;
    else if (cmd.sweep_step)     nx_raddr = hand_nxt;
    else if (cmd.walk_start)     nx_raddr = head_r;
    else if (cmd.walk_step)      nx_raddr = nx_rdata;
    else                         nx_raddr = slot_r;
  end

  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = pred_r;
    nx_wdata = nx_rdata;
    if (cmd.unlink && slot_r != head_r) begin
      nx_we = 1'b1;
    end else if (cmd.insert && count_r != '0) begin
      nx_we    = 1'b1;
      nx_waddr = tail_r;
      nx_wdata = slot_r;
    end
  end

  always_comb begin
    st.is_alloc     = (act_r == ACT_ALLOC);
    st.free_valid   = valid_r[findex_r];
    st.free_is_head = (findex_r == head_r);
    st.scan_free    = !valid_r[idx_r];
    st.scan_last    = (idx_r == lim_last);
    st.sweep_hit    = !ref_r[hand_nxt];
    st.walk_match   = (nx_rdata == slot_r);
    st.out_free     = !out_valid || out_ready;
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r    <= in_action;
      page_r   <= in_page_number;
      owner_r  <= in_owner_id;
      zero_r   <= in_zero_fill;
      findex_r <= in_frame_index;
      idx_r    <= '0;
    end
    if (cmd.scan_step) idx_r <= idx_r + 1'b1;
    if (cmd.scan_take) slot_r <= idx_r;
    if (cmd.take_free) slot_r <= findex_r;
    if (cmd.walk_start) pred_r <= head_r;
    if (cmd.walk_step) pred_r <= nx_rdata;
    if (cmd.sweep_step) begin
      pred_r <= hand_r;
      if (!ref_r[hand_nxt]) slot_r <= hand_nxt;
    end
    if (cmd.unlink && evict_r) begin
      vpage_r  <= po_rdata[PO_W-1:OWNER_BITS];
      vowner_r <= po_rdata[OWNER_BITS-1:0];
    end
    if (cmd.result) begin
      out_status       <= cmd.result_err;
      out_granted_slot <= (act_r == ACT_ALLOC) ? slot_r : '0;
      out_clear_frame  <= (act_r == ACT_ALLOC) ? zero_r : 1'b0;
      out_evicted      <= evict_r;
      out_victim_page  <= evict_r ? vpage_r : '0;
      out_victim_owner <= evict_r ? vowner_r : '0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= CNT_W'(FRAME_SLOTS);
      valid_r   <= '0;
      ref_r     <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      hand_r    <= '0;
      unset_r   <= 1'b1;
      count_r   <= '0;
      evict_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;

      if (cmd.result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.accept) evict_r <= 1'b0;

      if (cmd.sweep_step) begin
        hand_r  <= hand_nxt;
        unset_r <= 1'b0;
        if (ref_r[hand_nxt]) begin
          ref_r[hand_nxt] <= 1'b0;
        end else begin
          evict_r <= 1'b1;
        end
      end

      if (cmd.unlink) begin
        valid_r[slot_r] <= 1'b0;
        ref_r[slot_r]   <= 1'b0;
        count_r         <= count_r - 1'b1;
        if (count_r == CNT_W'(1)) begin
          // Last slot leaves: empty list, hand unset.
          unset_r <= 1'b1;
          head_r  <= '0;
          tail_r  <= '0;
        end else begin
          // Step the hand back off the removed slot, or unset it at the head.
          if (!unset_r && hand_r == slot_r) begin
            if (slot_r != head_r) hand_r <= pred_r;
            else                  unset_r <= 1'b1;
          end
          if (slot_r == head_r) begin
            head_r <= nx_rdata;
          end else if (tail_r == slot_r) begin
            tail_r <= pred_r;
          end
        end
      end

      if (cmd.insert) begin
        valid_r[slot_r] <= 1'b1;
        ref_r[slot_r]   <= 1'b1;
        if (count_r == '0) head_r <= slot_r;
        tail_r  <= slot_r;
        count_r <= count_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/clock_frame_replacement_core.sv
// Top level of the clock (second chance) frame replacement block.
//
//   Channel  Ports                 Handshake         Beat
//   in       in_*                  in_valid/ready    one request
//   out      out_*                 out_valid/ready   one result per request
//   cfg      cfg_we, cfg_wdata     write enable      frame limit
//
// One request at a time. Allocate with a free slot: scan to it, insert,
// done. Allocate with eviction: the full scan to the frame limit, a hand
// sweep (at most n+1 hand steps for n slots in use), unlink of the victim,
// insert, done. Free: walk from head to the predecessor, unlink, done; an
// empty slot is not_found. The loops are bounded by the single read
// port of the link RAM. Reset is synchronous; no clearing pass follows it.
// A stalled result holds in the output register while the next request is taken.
`default_nettype none

module clock_frame_replacement_core #(
  parameter int FRAME_SLOTS      = 64,
  parameter int PAGE_NUMBER_BITS = 20,
  parameter int OWNER_BITS       = 8,
  localparam int SLOT_W          = $clog2(FRAME_SLOTS),
  localparam int CNT_W           = $clog2(FRAME_SLOTS + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [CNT_W-1:0]            cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_action,
  input  wire logic [PAGE_NUMBER_BITS-1:0] in_page_number,
  input  wire logic [OWNER_BITS-1:0]       in_owner_id,
  input  wire logic                        in_zero_fill,
  input  wire logic [SLOT_W-1:0]           in_frame_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_status,
  output logic [SLOT_W-1:0]                out_granted_slot,
  output logic                             out_clear_frame,
  output logic                             out_evicted,
  output logic [PAGE_NUMBER_BITS-1:0]      out_victim_page,
  output logic [OWNER_BITS-1:0]            out_victim_owner
);
  import cfr_pkg::*;

  cmd_t  cmd;
  stat_t st;

  cfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  cfr_datapath #(
    .FRAME_SLOTS      (FRAME_SLOTS),
    .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS),
    .OWNER_BITS       (OWNER_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_action        (in_action),
    .in_page_number   (in_page_number),
    .in_owner_id      (in_owner_id),
    .in_zero_fill     (in_zero_fill),
    .in_frame_index   (in_frame_index),
    .cmd              (cmd),
    .st               (st),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_granted_slot (out_granted_slot),
    .out_clear_frame  (out_clear_frame),
    .out_evicted      (out_evicted),
    .out_victim_page  (out_victim_page),
    .out_victim_owner (out_victim_owner)
  );

  // One request in flight: no second beat right after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

  // Table updates never overlap.
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.unlink, cmd.insert, cmd.sweep_step, cmd.walk_step, cmd.scan_step}))
    else $error("conflicting datapath commands");

  // A result is only loaded when the output register can take it.
  a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result |-> st.out_free)
    else $error("result loaded over a pending beat");

  // A not_found result carries no eviction.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOT_FOUND |-> !out_evicted)
    else $error("failed free reports an eviction");

endmodule

`default_nettype wire
